// ===== rtl/plst_pkg.sv =====
// ----------------------------------------------------------------------------
// plst_pkg: shared types and codes
// Operation codes, status codes and sequencer states of the positional list
// store.
// ----------------------------------------------------------------------------
package plst_pkg;

  localparam int unsigned POS_W = 6;
  localparam int unsigned OP_W = 3;
  localparam int unsigned STAT_W = 3;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_POP_BACK   = 3'd1,
    OP_INSERT_AT  = 3'd2,
    OP_REMOVE_AT  = 3'd3,
    OP_INSERT_MID = 3'd4,
    OP_REMOVE_MID = 3'd5,
    OP_DUMP       = 3'd6
  } op_t;

  localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY     = 3'd1;
  localparam logic [STAT_W-1:0] STAT_TOO_LARGE = 3'd2;
  localparam logic [STAT_W-1:0] STAT_NEGATIVE  = 3'd3;
  localparam logic [STAT_W-1:0] STAT_FULL      = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_WR,
    S_REM_RD,
    S_REM_WR,
    S_DUMP_RD,
    S_DUMP_OUT
  } state_t;

endpackage

// ===== rtl/plst_ram.sv =====
// ----------------------------------------------------------------------------
// plst_ram: element storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module plst_ram #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_WIDTH-1:0]    wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_WIDTH-1:0]    rdata
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/positional_list_store_top.sv =====
// ----------------------------------------------------------------------------
// positional_list_store_top: ordered list with indexed insert and remove
// Push, pop, insert and remove at an index or the middle, and dump, run by a
// small sequencer that moves one element at a time through a simple dual-port
// ram.
// ----------------------------------------------------------------------------
// push, pop, errors, unused codes and empty dump: result in the cycle after the
//   transfer with busy low, so a transfer can be taken every cycle
// insert and remove: busy while elements are moved, one ram read and one ram write
//   per element moved; dump: busy while elements are read out, one result per element
// busy drops in the cycle of the final result, where the next transfer can be taken
// reset clears the count and the sequencer; ram contents are not cleared
module positional_list_store_top
  import plst_pkg::*;
#(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [OP_W-1:0]                in_operation,
  input  logic signed [POS_W-1:0]        in_position,
  input  logic [DATA_WIDTH-1:0]          in_data_word,
  output logic                           out_strobe,
  output logic [STAT_W-1:0]              out_status,
  output logic [DATA_WIDTH-1:0]          out_element_value,
  output logic [$clog2(DEPTH)-1:0]       out_element_position,
  output logic [$clog2(DEPTH+1)-1:0]     out_count_after,
  output logic                           out_last
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned MAG_W = POS_W - 1;
  localparam int unsigned CMP_W = CNT_W + MAG_W;

  state_t                 state_r, state_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [CNT_W-1:0]       idx_r, idx_nxt;
  logic [CNT_W-1:0]       tgt_r, tgt_nxt;
  logic [DATA_WIDTH-1:0]  data_r, data_nxt;

  logic                   strobe_r;
  logic [STAT_W-1:0]      status_r;
  logic [DATA_WIDTH-1:0]  value_r;
  logic [IDX_W-1:0]       pos_r;
  logic [CNT_W-1:0]       cnt_out_r;
  logic                   last_r;

  logic                   emit;
  logic [STAT_W-1:0]      emit_status;
  logic [DATA_WIDTH-1:0]  emit_value;
  logic [IDX_W-1:0]       emit_pos;
  logic                   emit_last;

  logic                   ram_we, ram_re;
  logic [IDX_W-1:0]       ram_waddr, ram_raddr;
  logic [DATA_WIDTH-1:0]  ram_wdata, ram_rdata;

  logic [CNT_W-1:0]       idx_inc, idx_dec, mid;
  logic [CMP_W-1:0]       pos_ext, cnt_ext, sel_ext;
  logic                   sel_neg, is_full, is_empty;
  logic                   accept;

  assign accept   = start && (state_r == S_IDLE);
  assign idx_inc  = idx_r + CNT_W'(1);
  assign idx_dec  = idx_r - CNT_W'(1);
  assign mid      = count_r >> 1;
  assign is_full  = (count_r == CNT_W'(DEPTH));
  assign is_empty = (count_r == '0);
  assign pos_ext  = {{CNT_W{1'b0}}, in_position[MAG_W-1:0]};
  assign cnt_ext  = {{MAG_W{1'b0}}, count_r};

  // index operand: the given position or the middle
  always_comb begin
    if (in_operation == OP_INSERT_AT || in_operation == OP_REMOVE_AT) begin
      sel_ext = pos_ext;
      sel_neg = in_position[POS_W-1];
    end else begin
      sel_ext = {{MAG_W{1'b0}}, mid};
      sel_neg = 1'b0;
    end
  end

  plst_ram #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    tgt_nxt     = tgt_r;
    data_nxt    = data_r;
    emit        = 1'b0;
    emit_status = STAT_OK;
    emit_value  = '0;
    emit_pos    = '0;
    emit_last   = 1'b1;
    ram_we      = 1'b0;
    ram_waddr   = idx_r[IDX_W-1:0];
    ram_wdata   = data_r;
    ram_re      = 1'b0;
    ram_raddr   = idx_r[IDX_W-1:0];
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          data_nxt = in_data_word;
          case (op_t'(in_operation))
            OP_PUSH_BACK: begin
              emit = 1'b1;
              if (is_full) begin
                emit_status = STAT_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = count_r[IDX_W-1:0];
                ram_wdata = in_data_word;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            OP_POP_BACK: begin
              emit = 1'b1;
              if (is_empty) begin
                emit_status = STAT_EMPTY;
              end else begin
                count_nxt = count_r - CNT_W'(1);
              end
            end
            OP_INSERT_AT, OP_INSERT_MID: begin
              if (!sel_neg && sel_ext >= cnt_ext) begin
                emit        = 1'b1;
                emit_status = STAT_TOO_LARGE;
              end else if (sel_neg) begin
                emit        = 1'b1;
                emit_status = STAT_NEGATIVE;
              end else if (is_full) begin
                emit        = 1'b1;
                emit_status = STAT_FULL;
              end else begin
                idx_nxt   = count_r;
                tgt_nxt   = sel_ext[CNT_W-1:0];
                state_nxt = S_INS_RD;
              end
            end
            OP_REMOVE_AT, OP_REMOVE_MID: begin
              if (in_operation == OP_REMOVE_MID && is_empty) begin
                emit        = 1'b1;
                emit_status = STAT_EMPTY;
              end else if (!sel_neg && sel_ext >= cnt_ext) begin
                emit        = 1'b1;
                emit_status = STAT_TOO_LARGE;
              end else if (sel_neg) begin
                emit        = 1'b1;
                emit_status = STAT_NEGATIVE;
              end else begin
                idx_nxt   = sel_ext[CNT_W-1:0];
                state_nxt = S_REM_RD;
              end
            end
            OP_DUMP: begin
              if (is_empty) begin
                emit        = 1'b1;
                emit_status = STAT_EMPTY;
              end else begin
                idx_nxt   = '0;
                state_nxt = S_DUMP_RD;
              end
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      // walk down from the back, moving each element up one place
      S_INS_RD: begin
        if (idx_r > tgt_r) begin
          ram_re    = 1'b1;
          ram_raddr = idx_dec[IDX_W-1:0];
          state_nxt = S_INS_WR;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = tgt_r[IDX_W-1:0];
          ram_wdata = data_r;
          count_nxt = count_r + CNT_W'(1);
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_INS_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r[IDX_W-1:0];
        ram_wdata = ram_rdata;
        idx_nxt   = idx_dec;
        state_nxt = S_INS_RD;
      end
      // walk up from the index, moving each later element down one place
      S_REM_RD: begin
        if (idx_inc < count_r) begin
          ram_re    = 1'b1;
          ram_raddr = idx_inc[IDX_W-1:0];
          state_nxt = S_REM_WR;
        end else begin
          count_nxt = count_r - CNT_W'(1);
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_REM_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r[IDX_W-1:0];
        ram_wdata = ram_rdata;
        idx_nxt   = idx_inc;
        state_nxt = S_REM_RD;
      end
      S_DUMP_RD: begin
        ram_re    = 1'b1;
        ram_raddr = idx_r[IDX_W-1:0];
        state_nxt = S_DUMP_OUT;
      end
      S_DUMP_OUT: begin
        emit       = 1'b1;
        emit_value = ram_rdata;
        emit_pos   = idx_r[IDX_W-1:0];
        emit_last  = (idx_inc == count_r);
        if (idx_inc == count_r) begin
          state_nxt = S_IDLE;
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = S_DUMP_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      strobe_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    tgt_r     <= tgt_nxt;
    data_r    <= data_nxt;
    status_r  <= emit_status;
    value_r   <= emit_value;
    pos_r     <= emit_pos;
    cnt_out_r <= count_nxt;
    last_r    <= emit_last;
  end

  assign busy                 = (state_r != S_IDLE);
  assign out_strobe           = strobe_r;
  assign out_status           = status_r;
  assign out_element_value    = value_r;
  assign out_element_position = pos_r;
  assign out_count_after      = cnt_out_r;
  assign out_last             = last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("element count above depth");

  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r |-> cnt_out_r == count_r)
    else $error("reported count differs from stored count");

  a_transfer_progress: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (busy || strobe_r))
    else $error("transfer produced neither work nor a result");

  a_dump_pos: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r |-> ({1'b0, pos_r} < CNT_W'(IDX_W'(0)) + cnt_out_r) || cnt_out_r == '0)
    else $error("dump position outside the list");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (strobe_r && last_r) |-> !busy)
    else $error("final result while still busy");

endmodule
